[design/cfba_pkg.sv]
// ----------------------------------------------------------------------------
// cfba_pkg: shared types and constants of the frame bitmap allocator
// Field widths, operation and status codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package cfba_pkg;

  localparam int unsigned FN_W  = 16;  // frame number
  localparam int unsigned CNT_W = 17;  // frame count, free count, total
  localparam int unsigned ST_W  = 2;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_COUNT = 2'd1,
    ST_TOO_BIG    = 2'd2,
    ST_NO_RUN     = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // write one all-ones word of the reset sweep
    logic load;       // capture a request
    logic div_step;   // split frame_number into map word and bit offset
    logic seed_free;  // set up the clear walk of a free request
    logic rd;         // read the map word at the working index
    logic scan_step;  // test one chunk of the current word
    logic mark_wr;    // write back one modified map word
    logic rsp_load;   // move the result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic req_free;
    logic req_err;
    logic free_skip;
    logic hit;
    logic scan_end;
    logic chunk_last;
    logic mark_last;
  } dp_sts_t;

endpackage

[design/cfba_req_if.sv]
// ----------------------------------------------------------------------------
// cfba_req_if: request channel of the frame bitmap allocator
// Valid/ready handshake carrying one alloc or free request.
// ----------------------------------------------------------------------------
interface cfba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [cfba_pkg::FN_W-1:0]     frame_number;
  logic [cfba_pkg::CNT_W-1:0]    count;

  modport source (output valid, func, frame_number, count, input ready);
  modport sink   (input valid, func, frame_number, count, output ready);
endinterface

[design/cfba_rsp_if.sv]
// ----------------------------------------------------------------------------
// cfba_rsp_if: response channel of the frame bitmap allocator
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface cfba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cfba_pkg::FN_W-1:0]     first_frame;
  logic [cfba_pkg::ST_W-1:0]     status;
  logic [cfba_pkg::CNT_W-1:0]    free_frames;

  modport source (output valid, first_frame, status, free_frames, input ready);
  modport sink   (input valid, first_frame, status, free_frames, output ready);
endinterface

[design/cfba_ram.sv]
// ----------------------------------------------------------------------------
// cfba_ram: generic single-port RAM
// One access per cycle, write or read; read data registered and held.
// ----------------------------------------------------------------------------
module cfba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                                      clk_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic                                      we_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/cfba_dp.sv]
// ----------------------------------------------------------------------------
// cfba_dp: datapath of the frame bitmap allocator
// Used-bit map RAM, chunked first-fit scan, word mask walk, word split, counts.
// ----------------------------------------------------------------------------
module cfba_dp #(
  parameter int unsigned MAX_FRAMES    = 65536,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfba_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  logic                           req_func_i,
  input  logic [cfba_pkg::FN_W-1:0]      req_frame_number_i,
  input  logic [cfba_pkg::CNT_W-1:0]     req_count_i,
  input  cfba_pkg::ctrl_cmd_t            cmd_i,
  output cfba_pkg::dp_sts_t              sts_o,
  output logic [cfba_pkg::FN_W-1:0]      rsp_first_frame_o,
  output logic [cfba_pkg::ST_W-1:0]      rsp_status_o,
  output logic [cfba_pkg::CNT_W-1:0]     rsp_free_frames_o
);

  localparam int unsigned CW        = cfba_pkg::CNT_W;
  localparam int unsigned FW        = cfba_pkg::FN_W;
  localparam int unsigned W         = MAP_WORD_BITS;
  localparam int unsigned MAP_WORDS = (MAX_FRAMES + W - 1) / W;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW        = $clog2(W);
  localparam int unsigned SB        = (W % 8 == 0) ? 8 : (W % 4 == 0) ? 4 :
                                      (W % 2 == 0) ? 2 : 1;
  localparam int unsigned SBW       = (SB > 1) ? $clog2(SB) : 1;
  localparam int unsigned LW        = ($clog2(MAX_FRAMES + 1) > CW) ?
                                      $clog2(MAX_FRAMES + 1) : CW;
  localparam int unsigned FREE_CAP  = (MAX_FRAMES > 131071) ? 131071 : MAX_FRAMES;
  // frame / W as a multiply by a rounded-up reciprocal, exact for FW-bit frames
  localparam int unsigned DV_SH     = FW + BW;
  localparam int unsigned DV_M      = ((1 << DV_SH) + W - 1) / W;
  localparam int unsigned DV_PW     = FW + FW + 1;

  // registers
  logic [CW-1:0]                tot_q;
  logic [CW-1:0]                fc_q;
  logic [AW-1:0]                clr_q;
  logic                         func_q;
  logic [CW-1:0]                count_q;
  logic [LW-1:0]                limit_q;
  logic [cfba_pkg::ST_W-1:0]    stat_q;
  logic [LW-1:0]                first_q;
  logic [AW-1:0]                word_q;
  logic [BW-1:0]                boff_q;
  logic [LW-1:0]                base_q;
  logic [CW-1:0]                run_q;
  logic [BW-1:0]                lo_q;
  logic [BW-1:0]                hi_q;
  logic [CW-1:0]                rem_q;
  logic [FW-1:0]                fn_q;
  logic [FW-1:0]                dv_rem_q;
  logic [FW-1:0]                dv_quo_q;
  logic [cfba_pkg::FN_W-1:0]    rsp_first_q;
  logic [cfba_pkg::ST_W-1:0]    rsp_status_q;
  logic [CW-1:0]                rsp_free_q;

  // map RAM
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [W-1:0]  ram_wdata;
  logic [W-1:0]  ram_rdata;

  cfba_ram #(
    .WIDTH (W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .rdata_o (ram_rdata)
  );

  // request checks
  logic [LW-1:0]             limit_c;
  logic [cfba_pkg::ST_W-1:0] early_st;

  always_comb begin
    limit_c = (LW'(tot_q) > LW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(tot_q);
    if (req_count_i == '0) begin
      early_st = cfba_pkg::ST_ZERO_COUNT;
    end else if (LW'(req_count_i) > limit_c) begin
      early_st = cfba_pkg::ST_TOO_BIG;
    end else begin
      early_st = cfba_pkg::ST_OK;
    end
  end

  // free count arithmetic
  logic [CW:0]   fc_sum;
  logic [CW-1:0] fc_add;
  logic [CW-1:0] fc_sub;

  always_comb begin
    fc_sum = {1'b0, fc_q} + {1'b0, req_count_i};
    fc_add = (fc_sum > (CW+1)'(FREE_CAP)) ? CW'(FREE_CAP) : fc_sum[CW-1:0];
    fc_sub = (fc_q > count_q) ? fc_q - count_q : '0;
  end

  // chunk scan: a run counter chained over SB bits
  logic [SB-1:0]  chunk;
  logic [CW-1:0]  scan_run;
  logic           scan_hit;
  logic [SBW-1:0] scan_hb;
  logic [LW:0]    base_nxt;
  logic           scan_end;
  logic           chunk_last;
  logic [LW-1:0]  f_end;

  always_comb begin
    chunk    = ram_rdata[boff_q +: SB];
    scan_run = run_q;
    scan_hit = 1'b0;
    scan_hb  = '0;
    for (int b = 0; b < SB; b++) begin
      if (!scan_hit) begin
        if (chunk[b] || ((base_q + LW'(b)) >= limit_q)) begin
          scan_run = '0;
        end else begin
          scan_run = scan_run + CW'(1);
        end
        if (scan_run == count_q) begin
          scan_hit = 1'b1;
          scan_hb  = SBW'(b);
        end
      end
    end
    base_nxt   = {1'b0, base_q} + (LW+1)'(SB);
    scan_end   = !scan_hit && (base_nxt >= {1'b0, limit_q});
    chunk_last = (boff_q == BW'(W - SB));
    f_end      = base_q + LW'(scan_hb);
  end

  // word mask for the mark / clear walk
  logic [BW:0]   avail;
  logic [BW-1:0] lo_m;
  logic [BW-1:0] hi_m;
  logic [BW:0]   n_m;
  logic [W-1:0]  mask;
  logic [CW-1:0] rem_nxt;
  logic [W-1:0]  mark_data;
  logic          mark_last;

  always_comb begin
    lo_m = lo_q;
    hi_m = hi_q;
    if (func_q == cfba_pkg::FUNC_FREE) begin
      // walk upward from lo_q
      avail = (BW+1)'(W) - (BW+1)'(lo_q);
      if (rem_q >= CW'(avail)) begin
        hi_m = BW'(W - 1);
        n_m  = avail;
      end else begin
        hi_m = BW'((BW+1)'(lo_q) + (BW+1)'(rem_q) - (BW+1)'(1));
        n_m  = (BW+1)'(rem_q);
      end
    end else begin
      // walk downward from hi_q
      avail = (BW+1)'(hi_q) + (BW+1)'(1);
      if (rem_q >= CW'(avail)) begin
        lo_m = '0;
        n_m  = avail;
      end else begin
        lo_m = BW'(avail - (BW+1)'(rem_q));
        n_m  = (BW+1)'(rem_q);
      end
    end
    for (int i = 0; i < W; i++) begin
      mask[i] = (BW'(i) >= lo_m) && (BW'(i) <= hi_m);
    end
    mark_data = (func_q == cfba_pkg::FUNC_FREE) ? (ram_rdata & ~mask) : (ram_rdata | mask);
    rem_nxt   = rem_q - CW'(n_m);
    mark_last = (rem_nxt == '0) ||
                ((func_q == cfba_pkg::FUNC_FREE) && (word_q == AW'(MAP_WORDS - 1)));
  end

  // frame number to map word and bit offset
  logic [DV_PW-1:0] dv_prod;
  logic [FW-1:0]    dv_quo;
  logic [FW-1:0]    dv_rem;

  always_comb begin
    dv_prod = DV_PW'(fn_q) * DV_PW'(DV_M);
    dv_quo  = FW'(dv_prod >> DV_SH);
    dv_rem  = fn_q - FW'(DV_PW'(dv_quo) * DV_PW'(W));
  end

  assign ram_addr  = cmd_i.clr_step ? clr_q : word_q;
  assign ram_we    = cmd_i.clr_step | cmd_i.mark_wr;
  assign ram_wdata = cmd_i.clr_step ? {W{1'b1}} : mark_data;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= cfba_pkg::TOTAL_RESET;
      fc_q  <= '0;
      clr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        tot_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load && (req_func_i == cfba_pkg::FUNC_FREE)) begin
        fc_q <= fc_add;
      end else if (cmd_i.scan_step && scan_hit) begin
        fc_q <= fc_sub;
      end
    end
  end

  // working and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= req_func_i;
      count_q  <= req_count_i;
      limit_q  <= limit_c;
      stat_q   <= (req_func_i == cfba_pkg::FUNC_FREE) ? cfba_pkg::ST_OK : early_st;
      first_q  <= '0;
      word_q   <= '0;
      boff_q   <= '0;
      base_q   <= '0;
      run_q    <= '0;
      fn_q     <= req_frame_number_i;
    end
    if (cmd_i.div_step) begin
      dv_quo_q <= dv_quo;
      dv_rem_q <= dv_rem;
    end
    if (cmd_i.seed_free) begin
      word_q <= AW'(dv_quo_q);
      lo_q   <= BW'(dv_rem_q);
      rem_q  <= count_q;
    end
    if (cmd_i.scan_step) begin
      run_q <= scan_run;
      if (scan_hit) begin
        hi_q    <= boff_q + BW'(scan_hb);
        rem_q   <= count_q;
        first_q <= f_end + LW'(1) - LW'(count_q);
      end else if (scan_end) begin
        stat_q <= cfba_pkg::ST_NO_RUN;
      end else begin
        base_q <= base_nxt[LW-1:0];
        if (chunk_last) begin
          boff_q <= '0;
          word_q <= word_q + AW'(1);
        end else begin
          boff_q <= boff_q + BW'(SB);
        end
      end
    end
    if (cmd_i.mark_wr) begin
      rem_q <= rem_nxt;
      if (func_q == cfba_pkg::FUNC_FREE) begin
        word_q <= word_q + AW'(1);
        lo_q   <= '0;
      end else begin
        word_q <= word_q - AW'(1);
        hi_q   <= BW'(W - 1);
      end
    end
    if (cmd_i.rsp_load) begin
      rsp_first_q  <= first_q[cfba_pkg::FN_W-1:0];
      rsp_status_q <= stat_q;
      rsp_free_q   <= fc_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (clr_q == AW'(MAP_WORDS - 1));
    sts_o.req_free   = (req_func_i == cfba_pkg::FUNC_FREE);
    sts_o.req_err    = (req_func_i == cfba_pkg::FUNC_ALLOC) && (early_st != cfba_pkg::ST_OK);
    sts_o.free_skip  = (count_q == '0) || (32'(dv_quo_q) >= 32'(MAP_WORDS));
    sts_o.hit        = scan_hit;
    sts_o.scan_end   = scan_end;
    sts_o.chunk_last = chunk_last;
    sts_o.mark_last  = mark_last;
  end

  assign rsp_first_frame_o = rsp_first_q;
  assign rsp_status_o      = rsp_status_q;
  assign rsp_free_frames_o = rsp_free_q;

endmodule

[design/cfba_ctrl.sv]
// ----------------------------------------------------------------------------
// cfba_ctrl: controller of the frame bitmap allocator
// Sequences the reset sweep, frame split, scan, mark/clear walk and response handshake.
// ----------------------------------------------------------------------------
module cfba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  input  cfba_pkg::dp_sts_t    sts_i,
  output cfba_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_DIV_END,
    S_SCAN_RD,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.req_free) begin
            state_d = S_DIV;
          end else if (sts_i.req_err) begin
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = S_DIV_END;
      end
      S_DIV_END: begin
        cmd_o.seed_free = 1'b1;
        state_d = sts_i.free_skip ? S_RESP : S_MARK_RD;
      end
      S_SCAN_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          state_d = S_MARK_RD;
        end else if (sts_i.scan_end) begin
          state_d = S_RESP;
        end else if (sts_i.chunk_last) begin
          state_d = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd_o.mark_wr = 1'b1;
        state_d = sts_i.mark_last ? S_RESP : S_MARK_RD;
      end
      S_RESP: begin
        // wait for the output register to drain
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.rsp_load = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

[design/contiguous_frame_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_frame_bitmap_allocator: first-fit contiguous page frame allocator
// Used-bit map in RAM with a free-frame count; alloc and free run requests.
// ----------------------------------------------------------------------------
// Reset: all frames used, free count zero; a sweep writes every map word to
//   all ones before the first request is taken.
// Alloc: each scanned word is read once, then tested one chunk (up to 8 bits)
//   per cycle; a hit leads to a read-modify-write of each word marked; errors go straight to the response.
// Free: a reciprocal-multiply frame-to-word split, then a read-modify-write of each word cleared.
// One request at a time; a result may wait in the output register meanwhile.
// ----------------------------------------------------------------------------
module contiguous_frame_bitmap_allocator #(
  parameter int unsigned MAX_FRAMES    = 65536,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cfba_pkg::CNT_W-1:0]  cfg_wdata_i,
  cfba_req_if.sink                    req_i,
  cfba_rsp_if.source                  rsp_o
);

  cfba_pkg::ctrl_cmd_t cmd;
  cfba_pkg::dp_sts_t   sts;

  cfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfba_dp #(
    .MAX_FRAMES    (MAX_FRAMES),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .req_func_i         (req_i.func),
    .req_frame_number_i (req_i.frame_number),
    .req_count_i        (req_i.count),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rsp_first_frame_o  (rsp_o.first_frame),
    .rsp_status_o       (rsp_o.status),
    .rsp_free_frames_o  (rsp_o.free_frames)
  );

endmodule

[sim/contiguous_frame_bitmap_allocator_test.sv]
// ----------------------------------------------------------------------------
// contiguous_frame_bitmap_allocator_test: self-checking bench of the allocator
// Mirrors the used-bit map and free count, runs directed corner requests and
// then random phases at several frame totals. Every response is checked.
// ----------------------------------------------------------------------------
module contiguous_frame_bitmap_allocator_test;

  localparam int unsigned FN_W          = cfba_pkg::FN_W;
  localparam int unsigned CNT_W         = cfba_pkg::CNT_W;
  localparam int unsigned MAX_FRAMES    = 65536;
  localparam int unsigned MAP_WORD_BITS = 32;
  localparam int unsigned MAP_WORDS     = MAX_FRAMES / MAP_WORD_BITS;
  localparam int unsigned FREE_CAP      = (MAX_FRAMES > 131071) ? 131071 : MAX_FRAMES;
  localparam int unsigned CNT_MAX       = 131071;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned SWAP_AT       = 280;
  localparam int unsigned CALM_AT       = 560;

  typedef struct packed {
    logic             func;
    logic [FN_W-1:0]  frame_number;
    logic [CNT_W-1:0] count;
  } frame_req_t;

  typedef struct packed {
    logic [FN_W-1:0]   first_frame;
    cfba_pkg::status_e status;
    logic [CNT_W-1:0]  free_frames;
  } frame_rsp_t;

  typedef struct {
    int unsigned first;
    int unsigned count;
  } frame_run_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             req_valid   = 1'b0;
  frame_req_t       req_data    = '0;
  logic             rsp_ready   = 1'b0;

  cfba_req_if req_if ();
  cfba_rsp_if rsp_if ();

  assign req_if.valid        = req_valid;
  assign req_if.func         = req_data.func;
  assign req_if.frame_number = req_data.frame_number;
  assign req_if.count        = req_data.count;
  assign rsp_if.ready        = rsp_ready;

  contiguous_frame_bitmap_allocator #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAP_WORD_BITS(MAP_WORD_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mirror of the allocator state
  logic [MAP_WORD_BITS-1:0] used_words [MAP_WORDS] = '{default: '1};
  int unsigned              free_total  = 0;
  int unsigned              frame_limit = cfba_pkg::TOTAL_RESET;

  frame_req_t  queued_reqs [$];
  frame_rsp_t  due_rsps [$];
  frame_run_t  held_runs [$];
  int unsigned accepted_reqs = 0;
  int unsigned cycle_cnt     = 0;
  bit          failed        = 1'b0;

  function automatic frame_rsp_t serve_request(frame_req_t r);
    frame_rsp_t  o;
    int unsigned lim, cnt, f, run, stop;
    bit          found;
    o.first_frame = '0;
    o.status      = cfba_pkg::ST_OK;
    cnt           = r.count;
    if (r.func == cfba_pkg::FUNC_ALLOC) begin
      lim = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
      if (cnt == 0) begin
        o.status = cfba_pkg::ST_ZERO_COUNT;
      end else if (cnt > lim) begin
        o.status = cfba_pkg::ST_TOO_BIG;
      end else begin
        f     = 0;
        run   = 0;
        found = 1'b0;
        while (!found && f < lim) begin
          // step over whole words where the run cannot end inside them
          if (f % MAP_WORD_BITS == 0 && f + MAP_WORD_BITS <= lim &&
              used_words[f / MAP_WORD_BITS] == '1) begin
            run = 0;
            f += MAP_WORD_BITS;
          end else if (f % MAP_WORD_BITS == 0 && f + MAP_WORD_BITS <= lim &&
                       used_words[f / MAP_WORD_BITS] == '0 && run + MAP_WORD_BITS < cnt) begin
            run += MAP_WORD_BITS;
            f += MAP_WORD_BITS;
          end else if (used_words[f / MAP_WORD_BITS][f % MAP_WORD_BITS]) begin
            run = 0;
            f++;
          end else begin
            run++;
            if (run == cnt) found = 1'b1;
            else f++;
          end
        end
        if (found) begin
          o.first_frame = FN_W'(f + 1 - cnt);
          for (int unsigned k = f + 1 - cnt; k <= f; k++)
            used_words[k / MAP_WORD_BITS][k % MAP_WORD_BITS] = 1'b1;
          free_total = (free_total > cnt) ? free_total - cnt : 0;
          held_runs.push_back('{first: f + 1 - cnt, count: cnt});
        end else begin
          o.status = cfba_pkg::ST_NO_RUN;
        end
      end
    end else begin
      // unchecked free: frames past the map are dropped, count still added
      stop = r.frame_number + cnt;
      for (int unsigned k = r.frame_number; k < stop && k < MAX_FRAMES; k++)
        used_words[k / MAP_WORD_BITS][k % MAP_WORD_BITS] = 1'b0;
      free_total += cnt;
      if (free_total > FREE_CAP) free_total = FREE_CAP;
    end
    o.free_frames = CNT_W'(free_total);
    return o;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) begin
        due_rsps.push_back(serve_request(queued_reqs.pop_front()));
        accepted_reqs++;
      end
      if (!req_valid || req_if.ready) begin
        if (queued_reqs.size() != 0 &&
            $urandom_range(99) >= (accepted_reqs < SWAP_AT ? 37 :
                                   accepted_reqs < CALM_AT ? 53 : 0)) begin
          req_valid <= 1'b1;
          req_data  <= queued_reqs[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin : rsp_monitor
    frame_rsp_t want;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        if (due_rsps.size() == 0) begin
          $error("unexpected response: first_frame %0d status %0d free_frames %0d",
                 rsp_if.first_frame, rsp_if.status, rsp_if.free_frames);
          failed = 1'b1;
        end else begin
          want = due_rsps.pop_front();
          if (rsp_if.first_frame !== want.first_frame) begin
            $error("first_frame: expected %0d, got %0d", want.first_frame, rsp_if.first_frame);
            failed = 1'b1;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            failed = 1'b1;
          end
          if (rsp_if.free_frames !== want.free_frames) begin
            $error("free_frames: expected %0d, got %0d", want.free_frames, rsp_if.free_frames);
            failed = 1'b1;
          end
        end
      end
      rsp_ready <= $urandom_range(99) >= (accepted_reqs < SWAP_AT ? 53 :
                                          accepted_reqs < CALM_AT ? 37 : 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("contiguous_frame_bitmap_allocator: mismatch");
      $finish;
    end
  end

  function automatic void push_req(logic func, int unsigned frame, int unsigned cnt);
    frame_req_t it;
    it.func         = func;
    it.frame_number = FN_W'(frame);
    it.count        = CNT_W'(cnt);
    queued_reqs.push_back(it);
  endfunction

  task automatic wait_sent();
    while (queued_reqs.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_quiet();
    while (queued_reqs.size() != 0 || due_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_total(int unsigned value);
    wait_quiet();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(value);
    frame_limit = value & CNT_MAX;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // alloc/free traffic, including frees of runs handed out earlier
  task automatic random_phase(int unsigned total_val, int unsigned n_items);
    int unsigned lim, sel, idx, cnt;
    frame_run_t  run;
    set_total(total_val);
    lim = (total_val > MAX_FRAMES) ? MAX_FRAMES : total_val;
    if (lim != 0) push_req(cfba_pkg::FUNC_FREE, 0, lim);  // boot map load
    for (int i = 0; i < n_items; i++) begin
      // let the mirror catch up so held_runs is current
      if (i % 8 == 0) wait_sent();
      sel = $urandom_range(99);
      if (sel < 45 && lim != 0) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(lim, 1)
                                       : $urandom_range((lim + 15) / 16, 1);
        push_req(cfba_pkg::FUNC_ALLOC, $urandom, cnt);
      end else if (sel < 80 && held_runs.size() != 0) begin
        idx = $urandom_range(held_runs.size() - 1);
        run = held_runs[idx];
        held_runs.delete(idx);
        push_req(cfba_pkg::FUNC_FREE, run.first, run.count);
      end else if (sel < 88) begin
        push_req(cfba_pkg::FUNC_FREE, $urandom_range(lim > 0 ? lim - 1 : 1023),
                 $urandom_range(64));
      end else if (sel < 94) begin
        case ($urandom_range(3))
          0:       cnt = 0;
          1:       cnt = lim;
          2:       cnt = lim + 1;
          default: cnt = $urandom_range(CNT_MAX);
        endcase
        push_req(cfba_pkg::FUNC_ALLOC, $urandom, cnt);
      end else begin
        cnt = ($urandom_range(15) == 0) ? $urandom_range(CNT_MAX) : $urandom_range(256);
        push_req(cfba_pkg::FUNC_FREE, $urandom, cnt);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // nothing is free after reset: full scan finds no run
    push_req(cfba_pkg::FUNC_ALLOC, 16'hFFFF, 1);
    push_req(cfba_pkg::FUNC_ALLOC, 0, 0);
    push_req(cfba_pkg::FUNC_ALLOC, 0, MAX_FRAMES + 1);
    push_req(cfba_pkg::FUNC_ALLOC, 16'hFFFF, CNT_MAX);
    push_req(cfba_pkg::FUNC_FREE, 16'hFFFF, 0);
    push_req(cfba_pkg::FUNC_FREE, 0, MAX_FRAMES);
    push_req(cfba_pkg::FUNC_FREE, 100, 10);               // free count held at its cap
    push_req(cfba_pkg::FUNC_ALLOC, 0, MAX_FRAMES);
    push_req(cfba_pkg::FUNC_ALLOC, 0, 1);
    push_req(cfba_pkg::FUNC_FREE, 65530, 100);            // runs off the top of the map
    push_req(cfba_pkg::FUNC_ALLOC, 0, 7);
    push_req(cfba_pkg::FUNC_ALLOC, 0, 6);
    push_req(cfba_pkg::FUNC_FREE, 0, 16);
    push_req(cfba_pkg::FUNC_ALLOC, 16'h8000, 16);
    push_req(cfba_pkg::FUNC_FREE, 40, 3);
    push_req(cfba_pkg::FUNC_FREE, 50, 5);
    push_req(cfba_pkg::FUNC_ALLOC, 0, 4);                 // must skip the 3-frame hole
    push_req(cfba_pkg::FUNC_ALLOC, 0, 3);
    push_req(cfba_pkg::FUNC_FREE, 16'hFFFF, 1);
    push_req(cfba_pkg::FUNC_ALLOC, 16'h5555, 2);

    random_phase(1, 30);
    random_phase(64, 150);
    random_phase(1000, 180);
    random_phase(2048, 170);
    random_phase(CNT_MAX, 40);                  // above capacity, acts as full map
    random_phase(0, 20);
    random_phase(300, 200);

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (!failed)
      $display("contiguous_frame_bitmap_allocator: match");
    else
      $display("contiguous_frame_bitmap_allocator: mismatch");
    $finish;
  end

endmodule

[sim.f]
design/cfba_pkg.sv
design/cfba_req_if.sv
design/cfba_rsp_if.sv
design/cfba_ram.sv
design/cfba_dp.sv
design/cfba_ctrl.sv
design/contiguous_frame_bitmap_allocator.sv
sim/contiguous_frame_bitmap_allocator_test.sv
